FILE: src/tgc_pkg.sv
package tgc_pkg;

  // timing and screen constants
  localparam int unsigned LONG_HOLD_MS  = 10000;
  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 240;

  localparam int unsigned PosW  = 12;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 28;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [PosW-1:0]  POS_MAX_X = PosW'(SCREEN_WIDTH - 1);
  localparam logic [PosW-1:0]  POS_MAX_Y = PosW'(SCREEN_HEIGHT - 1);
  localparam logic [TimeW-1:0] LONG_HOLD_LIM = TimeW'(LONG_HOLD_MS);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SHORT_MIN = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CALL_MIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HELP_MIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CAL_EN    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_X    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_X  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_Y    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_Y  = 3'd7;

  typedef enum logic [2:0] {
    GEST_TAP   = 3'd0,
    GEST_SHORT = 3'd1,
    GEST_CALL  = 3'd2,
    GEST_HELP  = 3'd3,
    GEST_LONG  = 3'd4
  } gesture_e;

endpackage

FILE: src/tgc_if.sv
interface tgc_in_if;
  import tgc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 touched;
  logic [TimeW-1:0]     now_ms;
  logic [PosW-1:0]      raw_x;
  logic [PosW-1:0]      raw_y;
  logic                 sample_ok;

  modport source (output valid, touched, now_ms, raw_x, raw_y, sample_ok, input ready);
  modport sink   (input valid, touched, now_ms, raw_x, raw_y, sample_ok, output ready);
endinterface

interface tgc_out_if;
  import tgc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 gesture_valid;
  logic [2:0]           gesture_code;
  logic                 holding;
  logic [PosW-1:0]      pos_x;
  logic [PosW-1:0]      pos_y;

  modport source (output valid, gesture_valid, gesture_code, holding, pos_x, pos_y,
                  input ready);
  modport sink   (input valid, gesture_valid, gesture_code, holding, pos_x, pos_y,
                  output ready);
endinterface

FILE: src/touch_gesture_classifier_core.sv
// channel   | dir | width of payload              | contents
// ----------+-----+-------------------------------+-------------------------------------
// tick_i    | in  | 1 + 32 + 12 + 12 + 1          | touched, now_ms, raw_x, raw_y, ok
// gesture_o | out | 1 + 3 + 1 + 12 + 12           | event flag, code, holding, position
// cfg_*_i   | in  | 3 index + 28 data             | thresholds, calibration gain/offset
//
// one request per cycle while the sink keeps up; path: input register, result register
// gesture state and one calibration multiply per axis update as a request advances
// async active-low reset clears all but the input payload; loads register defaults
// a stalled result holds in the output register while one more request waits in the input
// register; tick_i.ready drops only when both are full and the sink is not taking

module touch_gesture_classifier_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tgc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tgc_pkg::CfgW-1:0]       cfg_wdata_i,
  tgc_in_if.sink                         tick_i,
  tgc_out_if.source                      gesture_o
);
  import tgc_pkg::*;

  // linear calibration: gain * raw + offset in Q16, floored, clamped to [0, lim]
  function automatic logic [PosW-1:0] calib(input logic [PosW-1:0]   raw,
                                             input logic signed [19:0] gain,
                                             input logic signed [27:0] offs,
                                             input logic [PosW-1:0]   lim);
    logic signed [32:0] prod;
    logic signed [33:0] v;
    logic [17:0]        pix;
    logic [PosW-1:0]    res;
    prod = gain * $signed({1'b0, raw});
    v    = $signed({prod[32], prod}) + $signed({{6{offs[27]}}, offs});
    pix  = v[33:16];
    if (v[33]) begin
      res = '0;
    end else if (pix > {6'b0, lim}) begin
      res = lim;
    end else begin
      res = pix[PosW-1:0];
    end
    return res;
  endfunction

  // configuration registers
  logic [15:0]        short_min_q, call_min_q, help_min_q;
  logic               cal_en_q;
  logic signed [19:0] gain_x_q, gain_y_q;
  logic signed [27:0] offset_x_q, offset_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_min_q <= 16'd500;
      call_min_q  <= 16'd2000;
      help_min_q  <= 16'd3500;
      cal_en_q    <= 1'b0;
      gain_x_q    <= 20'sd65536;
      offset_x_q  <= '0;
      gain_y_q    <= 20'sd65536;
      offset_y_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHORT_MIN: short_min_q <= cfg_wdata_i[15:0];
        CFG_CALL_MIN:  call_min_q  <= cfg_wdata_i[15:0];
        CFG_HELP_MIN:  help_min_q  <= cfg_wdata_i[15:0];
        CFG_CAL_EN:    cal_en_q    <= cfg_wdata_i[0];
        CFG_GAIN_X:    gain_x_q    <= $signed(cfg_wdata_i[19:0]);
        CFG_OFFSET_X:  offset_x_q  <= $signed(cfg_wdata_i[27:0]);
        CFG_GAIN_Y:    gain_y_q    <= $signed(cfg_wdata_i[19:0]);
        CFG_OFFSET_Y:  offset_y_q  <= $signed(cfg_wdata_i[27:0]);
        default: ;
      endcase
    end
  end

  // input register
  logic             in_vld_q;
  logic             in_touched_q;
  logic [TimeW-1:0] in_now_q;
  logic [PosW-1:0]  in_x_q, in_y_q;
  logic             in_ok_q;

  // result register
  logic             out_vld_q;
  logic             out_gvalid_q;
  gesture_e         out_code_q;

  // gesture state
  logic             pressed_q, pressed_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             long_sent_q, long_sent_d;
  logic             prev_touch_q;
  logic [PosW-1:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic             hold_q, hold_d;

  logic             gvalid_d;
  gesture_e         code_d;
  logic [TimeW-1:0] dur;
  logic [PosW-1:0]  cal_x, cal_y;

  // compute fires when a request sits in the input register and the result slot frees
  logic advance;
  assign advance      = in_vld_q && (!out_vld_q || gesture_o.ready);
  assign tick_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (tick_i.ready) begin
      in_vld_q <= tick_i.valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (tick_i.ready && tick_i.valid) begin
      in_touched_q <= tick_i.touched;
      in_now_q     <= tick_i.now_ms;
      in_x_q       <= tick_i.raw_x;
      in_y_q       <= tick_i.raw_y;
      in_ok_q      <= tick_i.sample_ok;
    end
  end

  assign cal_x = calib(in_x_q, gain_x_q, offset_x_q, POS_MAX_X);
  assign cal_y = calib(in_y_q, gain_y_q, offset_y_q, POS_MAX_Y);
  assign dur   = in_now_q - start_q;  // wraps modulo 2^32

  always_comb begin
    pressed_d   = pressed_q;
    start_d     = start_q;
    long_sent_d = long_sent_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    hold_d      = hold_q;
    gvalid_d    = 1'b0;
    code_d      = GEST_TAP;
    if (!pressed_q) begin
      // new press only on a rising touch edge
      if (in_touched_q && !prev_touch_q) begin
        start_d     = in_now_q;
        long_sent_d = 1'b0;
        hold_d      = 1'b1;
        pressed_d   = 1'b1;
        if (in_ok_q) begin
          pos_x_d = cal_en_q ? cal_x : in_x_q;
          pos_y_d = cal_en_q ? cal_y : in_y_q;
        end
      end
    end else if (in_touched_q) begin
      if (!long_sent_q && (dur >= LONG_HOLD_LIM)) begin
        gvalid_d    = 1'b1;
        code_d      = GEST_LONG;
        long_sent_d = 1'b1;
      end
    end else begin
      // release: classify by hold time unless a long hold already went out
      hold_d    = 1'b0;
      pressed_d = 1'b0;
      if (!long_sent_q) begin
        gvalid_d = 1'b1;
        priority if (dur < {16'b0, short_min_q}) begin
          code_d = GEST_TAP;
        end else if (dur < {16'b0, call_min_q}) begin
          code_d = GEST_SHORT;
        end else if (dur < {16'b0, help_min_q}) begin
          code_d = GEST_CALL;
        end else begin
          code_d = GEST_HELP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q    <= 1'b0;
      start_q      <= '0;
      long_sent_q  <= 1'b0;
      prev_touch_q <= 1'b0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      hold_q       <= 1'b0;
      out_vld_q    <= 1'b0;
      out_gvalid_q <= 1'b0;
      out_code_q   <= GEST_TAP;
    end else begin
      if (advance) begin
        pressed_q    <= pressed_d;
        start_q      <= start_d;
        long_sent_q  <= long_sent_d;
        prev_touch_q <= in_touched_q;
        pos_x_q      <= pos_x_d;
        pos_y_q      <= pos_y_d;
        hold_q       <= hold_d;
        out_gvalid_q <= gvalid_d;
        out_code_q   <= code_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (gesture_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // holding and position in the result are the state after the request
  assign gesture_o.valid         = out_vld_q;
  assign gesture_o.gesture_valid = out_gvalid_q;
  assign gesture_o.gesture_code  = out_code_q;
  assign gesture_o.holding       = hold_q;
  assign gesture_o.pos_x         = pos_x_q;
  assign gesture_o.pos_y         = pos_y_q;

`ifndef ASSERT_OFF
  a_hold_tracks_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q == pressed_q)
    else $error("holding flag out of step with press phase");

  a_long_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_gvalid_q && out_code_q == GEST_LONG |-> hold_q)
    else $error("long hold posted while not holding");

  a_release_drops_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_gvalid_q && out_code_q != GEST_LONG |-> !hold_q)
    else $error("release event posted while still holding");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !gesture_o.ready |-> !tick_i.ready)
    else $error("input taken while both stages are full");

  a_no_event_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_gvalid_q |-> out_code_q == GEST_TAP)
    else $error("nonzero code without an event");
`endif

endmodule
